[rtl/pts_pkg.sv]
// ============================================================================
// pts_pkg
// Shared constants and command codes for the priority task scheduler.
// ============================================================================
package pts_pkg;

    // Default sizes of the scheduler.
    localparam int NUM_TASKS_DEF = 8;
    localparam int NUM_PRIOS_DEF = 32;

    // Lock nesting saturates at this depth.
    localparam logic [7:0] LOCK_MAX = 8'd255;

    // Time slice length after reset.
    localparam logic [7:0] SLICE_RESET = 8'd10;

    // Stream widths in bits, padded to whole bytes.
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // Command codes.
    localparam logic [2:0] OP_READY    = 3'd0;
    localparam logic [2:0] OP_UNREADY  = 3'd1;
    localparam logic [2:0] OP_DELAY    = 3'd2;
    localparam logic [2:0] OP_WAKE     = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;
    localparam logic [2:0] OP_LOCK     = 3'd5;
    localparam logic [2:0] OP_UNLOCK   = 3'd6;
    localparam logic [2:0] OP_SCHEDULE = 3'd7;

endpackage

[rtl/priority_task_scheduler.sv]
// ============================================================================
// priority_task_scheduler
// RTOS task scheduler with per-priority FIFO queues, a ready bitmap, a delay
// list with tick countdown, round-robin time slices and a lock depth.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  s_axis    in         one command: op (tuser), task_id, prio, wait_ticks
//  m_axis    out        one result: switched, running_task, running_valid,
//                       lock_depth, ready_map
//  cfg       in         slice_reload write
//
//  Ready, unready, delay wait, wake and lock pass through the execute and
//  done states; schedule and an unlock that reaches zero add a schedule state.
//  A tick walks the delay list, one entry per cycle through the shared 32-bit
//  countdown, then takes a slice step and a schedule step.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  A stalled result holds in the output register; the sequencer waits for it.
//
module priority_task_scheduler #(
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
    parameter int NUM_PRIOS = pts_pkg::NUM_PRIOS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tuser: op[2:0]
    // tdata: task_id[2:0], prio[7:3], wait_ticks[39:8]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2:0]                     s_axis_tuser,
    input  logic [pts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tdata: switched[0], running_task[3:1], running_valid[4],
    //        lock_depth[12:5], ready_map[44:13], zeros
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [7:0]                     cfg_data
);

    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_SLICE,
        S_SCHED,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              op_reg, op_next;
    logic [2:0]              tid_reg, tid_next;
    logic [4:0]              pin_reg, pin_next;
    logic [31:0]             ticks_reg, ticks_next;

    logic [PW-1:0]           prio_reg [NUM_TASKS];
    logic [PW-1:0]           prio_next [NUM_TASKS];
    logic [TW-1:0]           rank_reg [NUM_TASKS];
    logic [TW-1:0]           rank_next [NUM_TASKS];
    logic [NUM_TASKS-1:0]    ready_reg, ready_next;
    logic [NUM_PRIOS-1:0]    bitmap_reg, bitmap_next;
    logic [31:0]             wait_reg [NUM_TASKS];
    logic [31:0]             wait_next [NUM_TASKS];
    logic [NUM_TASKS-1:0]    dly_reg, dly_next;
    logic [TW-1:0]           age_reg [NUM_TASKS];
    logic [TW-1:0]           age_next [NUM_TASKS];
    logic [7:0]              slice_reg [NUM_TASKS];
    logic [7:0]              slice_next [NUM_TASKS];
    logic [TW-1:0]           order_reg [NUM_TASKS];
    logic [TW-1:0]           order_next [NUM_TASKS];
    logic [NUM_TASKS-1:0]    has_reg, has_next;
    logic [TW-1:0]           idx_reg, idx_next;
    logic [7:0]              lock_reg, lock_next;
    logic [TW-1:0]           cur_reg, cur_next;
    logic                    cur_valid_reg, cur_valid_next;
    logic [7:0]              reload_reg, reload_next;
    logic                    sw_reg, sw_next;
    logic                    out_valid_reg, out_valid_next;
    logic [pts_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                    pick_found;
    logic [TW-1:0]           pick_task;

    // Head-of-queue search for the schedule step.
    pts_head_pick #(
        .NUM_TASKS(NUM_TASKS),
        .NUM_PRIOS(NUM_PRIOS)
    ) u_pick (
        .bitmap(bitmap_reg),
        .ready (ready_reg),
        .prio  (prio_reg),
        .rank  (rank_reg),
        .found (pick_found),
        .pick  (pick_task)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    // Sequencer and all list updates.
    always_comb
    begin
        logic          tid_ok;
        logic [TW-1:0] t;
        logic [TW-1:0] e;
        logic [TW-1:0] c;
        logic [PW-1:0] pr;
        logic [PW-1:0] pe;
        logic [TW:0]   cnt;
        logic [7:0]    s;

        state_next     = state_reg;
        op_next        = op_reg;
        tid_next       = tid_reg;
        pin_next       = pin_reg;
        ticks_next     = ticks_reg;
        prio_next      = prio_reg;
        rank_next      = rank_reg;
        ready_next     = ready_reg;
        bitmap_next    = bitmap_reg;
        wait_next      = wait_reg;
        dly_next       = dly_reg;
        age_next       = age_reg;
        slice_next     = slice_reg;
        order_next     = order_reg;
        has_next       = has_reg;
        idx_next       = idx_reg;
        lock_next      = lock_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        reload_next    = reload_reg;
        sw_next        = sw_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        tid_ok = (7'(tid_reg) < 7'(NUM_TASKS));
        t      = TW'(tid_reg);
        pr     = (7'(pin_reg) >= 7'(NUM_PRIOS)) ? PW'(NUM_PRIOS - 1) : PW'(pin_reg);
        e      = order_reg[idx_reg];
        c      = cur_reg;
        pe     = prio_reg[e];
        cnt    = '0;
        s      = slice_reg[c] - 8'd1;

        if (cfg_valid)
        begin
            reload_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    tid_next   = s_axis_tdata[2:0];
                    pin_next   = s_axis_tdata[7:3];
                    ticks_next = s_axis_tdata[39:8];
                    sw_next    = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    pts_pkg::OP_READY:
                    begin
                        if (tid_ok && !ready_reg[t])
                        begin
                            prio_next[t] = pr;
                            for (int u = 0; u < NUM_TASKS; u++)
                            begin
                                if (ready_reg[u] && prio_reg[u] == pr)
                                begin
                                    cnt = cnt + 1'b1;
                                end
                            end
                            rank_next[t]   = TW'(cnt);
                            ready_next[t]  = 1'b1;
                            bitmap_next[pr] = 1'b1;
                        end
                    end
                    pts_pkg::OP_UNREADY:
                    begin
                        if (tid_ok && ready_reg[t])
                        begin
                            ready_next[t] = 1'b0;
                            for (int u = 0; u < NUM_TASKS; u++)
                            begin
                                if (TW'(u) != t && ready_reg[u] &&
                                    prio_reg[u] == prio_reg[t])
                                begin
                                    cnt = cnt + 1'b1;
                                    if (rank_reg[u] > rank_reg[t])
                                    begin
                                        rank_next[u] = rank_reg[u] - 1'b1;
                                    end
                                end
                            end
                            if (cnt == '0)
                            begin
                                bitmap_next[prio_reg[t]] = 1'b0;
                            end
                        end
                    end
                    pts_pkg::OP_DELAY:
                    begin
                        if (tid_ok)
                        begin
                            // Older entries age by one; those behind the
                            // task's old place keep their age.
                            for (int u = 0; u < NUM_TASKS; u++)
                            begin
                                if (TW'(u) != t && dly_reg[u] &&
                                    !(dly_reg[t] && age_reg[u] > age_reg[t]))
                                begin
                                    age_next[u] = age_reg[u] + 1'b1;
                                end
                            end
                            age_next[t]  = '0;
                            dly_next[t]  = 1'b1;
                            wait_next[t] = ticks_reg;
                        end
                    end
                    pts_pkg::OP_WAKE:
                    begin
                        if (tid_ok && dly_reg[t])
                        begin
                            for (int u = 0; u < NUM_TASKS; u++)
                            begin
                                if (dly_reg[u] && age_reg[u] > age_reg[t])
                                begin
                                    age_next[u] = age_reg[u] - 1'b1;
                                end
                            end
                            dly_next[t] = 1'b0;
                            age_next[t] = '0;
                        end
                    end
                    pts_pkg::OP_TICK:
                    begin
                        // Snapshot the delay list in age order.
                        has_next = '0;
                        for (int u = 0; u < NUM_TASKS; u++)
                        begin
                            if (dly_reg[u])
                            begin
                                order_next[age_reg[u]] = TW'(u);
                                has_next[age_reg[u]]   = 1'b1;
                            end
                        end
                        idx_next   = '0;
                        state_next = S_WALK;
                    end
                    pts_pkg::OP_LOCK:
                    begin
                        if (lock_reg != pts_pkg::LOCK_MAX)
                        begin
                            lock_next = lock_reg + 8'd1;
                        end
                    end
                    pts_pkg::OP_UNLOCK:
                    begin
                        if (lock_reg != 8'd0)
                        begin
                            lock_next = lock_reg - 8'd1;
                            if (lock_reg == 8'd1)
                            begin
                                state_next = S_SCHED;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_SCHED;
                    end
                endcase
            end

            S_WALK:
            begin
                // One delay list entry per cycle through the shared countdown.
                if (has_reg[idx_reg])
                begin
                    if (wait_reg[e] <= 32'd1)
                    begin
                        wait_next[e] = '0;
                        for (int u = 0; u < NUM_TASKS; u++)
                        begin
                            if (dly_reg[u] && age_reg[u] > age_reg[e])
                            begin
                                age_next[u] = age_reg[u] - 1'b1;
                            end
                        end
                        dly_next[e] = 1'b0;
                        age_next[e] = '0;
                        if (!ready_reg[e])
                        begin
                            for (int u = 0; u < NUM_TASKS; u++)
                            begin
                                if (ready_reg[u] && prio_reg[u] == pe)
                                begin
                                    cnt = cnt + 1'b1;
                                end
                            end
                            rank_next[e]    = TW'(cnt);
                            ready_next[e]   = 1'b1;
                            bitmap_next[pe] = 1'b1;
                        end
                    end
                    else
                    begin
                        wait_next[e] = wait_reg[e] - 32'd1;
                    end
                end
                if (idx_reg == TW'(NUM_TASKS - 1))
                begin
                    state_next = S_SLICE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_SLICE:
            begin
                // Running task's slice; on expiry it moves to its queue tail.
                if (cur_valid_reg)
                begin
                    if (s == 8'd0)
                    begin
                        slice_next[c] = reload_reg;
                        if (ready_reg[c])
                        begin
                            for (int u = 0; u < NUM_TASKS; u++)
                            begin
                                if (TW'(u) != c && ready_reg[u] &&
                                    prio_reg[u] == prio_reg[c])
                                begin
                                    cnt = cnt + 1'b1;
                                    if (rank_reg[u] > rank_reg[c])
                                    begin
                                        rank_next[u] = rank_reg[u] - 1'b1;
                                    end
                                end
                            end
                            rank_next[c] = TW'(cnt);
                        end
                    end
                    else
                    begin
                        slice_next[c] = s;
                    end
                end
                state_next = S_SCHED;
            end

            S_SCHED:
            begin
                if (lock_reg == 8'd0 && pick_found &&
                    !(cur_valid_reg && cur_reg == pick_task))
                begin
                    cur_next       = pick_task;
                    cur_valid_next = 1'b1;
                    sw_next        = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, 32'(bitmap_reg), lock_reg,
                                      cur_valid_reg, 3'(cur_reg), sw_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, list state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= '0;
            bitmap_reg    <= '0;
            dly_reg       <= '0;
            has_reg       <= '0;
            idx_reg       <= '0;
            lock_reg      <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            reload_reg    <= pts_pkg::SLICE_RESET;
            sw_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int u = 0; u < NUM_TASKS; u++)
            begin
                age_reg[u]   <= '0;
                slice_reg[u] <= pts_pkg::SLICE_RESET;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            bitmap_reg    <= bitmap_next;
            dly_reg       <= dly_next;
            has_reg       <= has_next;
            idx_reg       <= idx_next;
            lock_reg      <= lock_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            reload_reg    <= reload_next;
            sw_reg        <= sw_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            age_reg       <= age_next;
            slice_reg     <= slice_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tid_reg      <= tid_next;
        pin_reg      <= pin_next;
        ticks_reg    <= ticks_next;
        prio_reg     <= prio_next;
        rank_reg     <= rank_next;
        wait_reg     <= wait_next;
        order_reg    <= order_next;
    end

    // Once a task has been chosen there is always a running task.
    a_cur_valid_stays: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |=> cur_valid_reg)
        else $error("running task became invalid");

    // An accepted command blocks the next one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted while busy");

    // An empty bitmap means no task sits in any ready queue.
    a_bitmap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (bitmap_reg == '0) |-> (ready_reg == '0))
        else $error("ready task with empty bitmap");

    // A reported switch always comes with a valid running task.
    a_switch_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[0]) |-> out_data_reg[4])
        else $error("switch reported without running task");

endmodule

[rtl/pts_head_pick.sv]
// ============================================================================
// pts_head_pick
// Finds the highest non-empty priority and the task at the head of its queue.
// ============================================================================
module pts_head_pick #(
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
    parameter int NUM_PRIOS = pts_pkg::NUM_PRIOS_DEF,
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1,
    localparam int PW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1
) (
    input  logic [NUM_PRIOS-1:0] bitmap,
    input  logic [NUM_TASKS-1:0] ready,
    input  logic [PW-1:0]        prio [NUM_TASKS],
    input  logic [TW-1:0]        rank [NUM_TASKS],
    output logic                 found,
    output logic [TW-1:0]        pick
);

    logic [PW-1:0] top_prio;
    logic          head_hit;

    // Lowest set bit of the bitmap is the highest priority.
    always_comb
    begin
        top_prio = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--)
        begin
            if (bitmap[i])
            begin
                top_prio = PW'(i);
            end
        end
    end

    // The head of a queue is the ready task of that priority with rank zero.
    always_comb
    begin
        head_hit = 1'b0;
        pick     = '0;
        for (int t = NUM_TASKS - 1; t >= 0; t--)
        begin
            if (ready[t] && prio[t] == top_prio && rank[t] == '0)
            begin
                head_hit = 1'b1;
                pick     = TW'(t);
            end
        end
    end

    assign found = (|bitmap) && head_hit;

endmodule

[sim/pts_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// pts_checker
// Watches the command, result and slice-length channels of the scheduler.
// It keeps its own copy of the ready queues, delay list and slice counters,
// works out the result of every accepted command and compares it, field by
// field, with the oldest result still owed.
// ============================================================================
module pts_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [2:0]                     s_axis_tuser,
    input  logic [pts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [pts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [7:0]                     cfg_data,
    output int                             errors,
    output int                             owed
);

    localparam int NT = pts_pkg::NUM_TASKS_DEF;
    localparam int NP = pts_pkg::NUM_PRIOS_DEF;

    // Packed from the top bit down, so switched lands in bit 0.
    typedef struct packed {
        logic [31:0] ready_map;
        logic [7:0]  lock_depth;
        logic        running_valid;
        logic [2:0]  running_task;
        logic        switched;
    } sched_status_t;

    // Scheduler state as the block should hold it.
    logic [7:0]  slice_len;
    logic [4:0]  prio_of   [NT];
    logic [2:0]  link      [NT];
    logic [2:0]  head      [NP];
    logic [2:0]  tail      [NP];
    int          depth     [NP];
    logic [31:0] bitmap;
    logic [31:0] countdown [NT];
    logic        delayed   [NT];
    int          age       [NT];
    logic [7:0]  slice_cnt [NT];
    logic        queued    [NT];
    logic [7:0]  locks;
    logic [2:0]  cur;
    logic        cur_ok;

    sched_status_t status_q[$];

    function automatic void push_ready(input int t);
        int p;
        p = int'(prio_of[t]);
        if (queued[t]) return;
        link[t] = '0;
        if (depth[p] == 0) head[p] = 3'(t);
        else link[tail[p]] = 3'(t);
        tail[p] = 3'(t);
        depth[p]++;
        bitmap[p] = 1'b1;
        queued[t] = 1'b1;
    endfunction

    function automatic void pull_ready(input int t);
        int p, c, prv, i;
        bit has_prv, hit;
        p = int'(prio_of[t]);
        has_prv = 0;
        hit = 0;
        prv = 0;
        if (!queued[t]) return;
        queued[t] = 1'b0;
        c = int'(head[p]);
        for (i = 0; i < depth[p]; i++) begin
            if (c == t) begin
                hit = 1;
                break;
            end
            prv = c;
            has_prv = 1;
            c = int'(link[c]);
        end
        if (!hit) return;
        if (has_prv) link[prv] = link[t];
        else head[p] = link[t];
        if (int'(tail[p]) == t && has_prv) tail[p] = 3'(prv);
        depth[p]--;
        if (depth[p] == 0) bitmap[p] = 1'b0;
    endfunction

    function automatic void unlink_delay(input int t);
        if (!delayed[t]) return;
        for (int u = 0; u < NT; u++)
            if (delayed[u] && age[u] > age[t]) age[u]--;
        delayed[t] = 1'b0;
        age[t] = 0;
    endfunction

    function automatic logic pick_next();
        int p;
        if (locks != 0 || bitmap == 0) return 1'b0;
        for (p = 0; p < NP; p++)
            if (bitmap[p]) break;
        if (cur_ok && cur == head[p]) return 1'b0;
        cur = head[p];
        cur_ok = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic run_tick();
        int order [NT];
        bit has [NT];
        int t;
        for (int a = 0; a < NT; a++) has[a] = 0;
        for (t = 0; t < NT; t++)
            if (delayed[t]) begin
                order[age[t]] = t;
                has[age[t]] = 1;
            end
        for (int a = 0; a < NT; a++) begin
            if (!has[a]) continue;
            t = order[a];
            if (countdown[t] <= 1) begin
                countdown[t] = 0;
                unlink_delay(t);
                push_ready(t);
            end else begin
                countdown[t]--;
            end
        end
        if (cur_ok) begin
            slice_cnt[cur] = slice_cnt[cur] - 8'd1;
            if (slice_cnt[cur] == 0) begin
                if (queued[cur]) begin
                    pull_ready(int'(cur));
                    push_ready(int'(cur));
                end
                slice_cnt[cur] = slice_len;
            end
        end
        return pick_next();
    endfunction

    // Apply one command beat and return the status it should produce.
    function automatic sched_status_t apply_command(input logic [2:0] op,
                                                    input logic [pts_pkg::IN_DATA_W-1:0] d);
        int          t;
        logic [4:0]  pr;
        logic [31:0] ticks;
        logic        sw;
        sched_status_t r;
        t = int'(d[2:0]);
        pr = d[7:3];
        ticks = d[39:8];
        sw = 1'b0;
        case (op)
            pts_pkg::OP_READY:
                if (!queued[t]) begin
                    prio_of[t] = pr;
                    push_ready(t);
                end
            pts_pkg::OP_UNREADY: pull_ready(t);
            pts_pkg::OP_DELAY:
            begin
                unlink_delay(t);
                for (int u = 0; u < NT; u++)
                    if (delayed[u]) age[u]++;
                age[t] = 0;
                delayed[t] = 1'b1;
                countdown[t] = ticks;
            end
            pts_pkg::OP_WAKE: unlink_delay(t);
            pts_pkg::OP_TICK: sw = run_tick();
            pts_pkg::OP_LOCK: if (locks != pts_pkg::LOCK_MAX) locks++;
            pts_pkg::OP_UNLOCK:
                if (locks != 0) begin
                    locks--;
                    if (locks == 0) sw = pick_next();
                end
            default: sw = pick_next();
        endcase
        r.switched = sw;
        r.running_task = cur;
        r.running_valid = cur_ok;
        r.lock_depth = locks;
        r.ready_map = bitmap;
        return r;
    endfunction

    assign owed = status_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        sched_status_t got, want;
        if (!rst_n) begin
            slice_len = pts_pkg::SLICE_RESET;
            for (int i = 0; i < NT; i++) begin
                prio_of[i] = 0;
                link[i] = 0;
                countdown[i] = 0;
                delayed[i] = 0;
                age[i] = 0;
                slice_cnt[i] = pts_pkg::SLICE_RESET;
                queued[i] = 0;
            end
            for (int i = 0; i < NP; i++) begin
                head[i] = 0;
                tail[i] = 0;
                depth[i] = 0;
            end
            bitmap = 0;
            locks = 0;
            cur = 0;
            cur_ok = 0;
            errors = 0;
            status_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) slice_len = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                status_q.push_back(apply_command(s_axis_tuser, s_axis_tdata));
            // Compare each result beat with the oldest one owed.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[44:0];
                if (status_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("checker: unexpected result beat %h", got);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"checker: mismatch sw %b/%b task %0d/%0d vld %b/%b ",
                                      "lock %0d/%0d map %h/%h (expected/actual)"},
                                     want.switched, got.switched,
                                     want.running_task, got.running_task,
                                     want.running_valid, got.running_valid,
                                     want.lock_depth, got.lock_depth,
                                     want.ready_map, got.ready_map);
                    end
                end
            end
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Command stimulus for the priority task scheduler.
// Runs directed corner cases, then random command streams under several
// idle and stall patterns, and changes the slice length between phases.
// ============================================================================
module testbench;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [2:0]                     s_axis_tuser;
    logic [pts_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [pts_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [7:0]                     cfg_data;
    int                             errors;
    int                             owed;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  quiet_cycles;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    priority_task_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    pts_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .owed(owed)
    );

    // Result-side stalls; a long hold-off lets the block back up.
    always @(posedge clk)
    begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no beat moving on the command or result channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Offer one command beat and wait for it to be taken; valid stays up
    // for a following beat and drops only on an idle cycle.
    task automatic send_cmd(input logic [2:0] op, input logic [2:0] t,
                            input logic [4:0] pr, input logic [31:0] ticks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {ticks, pr, t};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic write_slice(input logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        while (owed != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ready/tick/schedule traffic with short delays so tasks cycle.
    task automatic random_cmds(input int n);
        logic [2:0]  op;
        logic [31:0] ticks;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 25) op = pts_pkg::OP_READY;
            else if (r < 35) op = pts_pkg::OP_UNREADY;
            else if (r < 47) op = pts_pkg::OP_DELAY;
            else if (r < 53) op = pts_pkg::OP_WAKE;
            else if (r < 75) op = pts_pkg::OP_TICK;
            else if (r < 81) op = pts_pkg::OP_LOCK;
            else if (r < 88) op = pts_pkg::OP_UNLOCK;
            else op = pts_pkg::OP_SCHEDULE;
            ticks = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(5);
            send_cmd(op, 3'($urandom_range(7)), 5'($urandom_range(31)), ticks);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of fields and every command.
        send_cmd(pts_pkg::OP_SCHEDULE, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_TICK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_READY, 3'd7, 5'd31, 32'hFFFF_FFFF);
        send_cmd(pts_pkg::OP_READY, 3'd7, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_READY, 3'd0, 5'd31, 32'd0);
        send_cmd(pts_pkg::OP_READY, 3'd1, 5'd31, 32'd0);
        send_cmd(pts_pkg::OP_SCHEDULE, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_DELAY, 3'd2, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_DELAY, 3'd3, 5'd0, 32'hFFFF_FFFF);
        send_cmd(pts_pkg::OP_DELAY, 3'd2, 5'd0, 32'd1);
        send_cmd(pts_pkg::OP_WAKE, 3'd4, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_READY, 3'd2, 5'd5, 32'd0);
        send_cmd(pts_pkg::OP_UNREADY, 3'd2, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_UNREADY, 3'd5, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_LOCK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_TICK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_UNLOCK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_UNLOCK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_WAKE, 3'd3, 5'd0, 32'd0);

        // Random phases with different slice lengths.
        write_slice(8'd1);
        random_cmds(60);
        write_slice(8'd255);
        send_idle_pct = 73;
        random_cmds(60);
        write_slice(8'd3);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        random_cmds(60);
        write_slice(8'd2);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        random_cmds(60);

        // Back-pressure: hold results off while commands keep coming.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            random_cmds(30);
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join

        // Lock saturation last, so the rest of the run is not left locked.
        for (int i = 0; i < 256; i++) send_cmd(pts_pkg::OP_LOCK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_TICK, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_SCHEDULE, 3'd0, 5'd0, 32'd0);
        send_cmd(pts_pkg::OP_UNLOCK, 3'd0, 5'd0, 32'd0);
        s_axis_tvalid <= 1'b0;

        while (owed != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

[priority_task_scheduler.f]
rtl/pts_pkg.sv
rtl/pts_head_pick.sv
rtl/priority_task_scheduler.sv
sim/pts_checker.sv
sim/testbench.sv
